/* design/lbc_pkg.sv */
// lbc_pkg: shared widths, register codes, control word and microprogram
// for the low-pass biquad cascade filter
// no dependencies; every other design file imports this package

package lbc_pkg;

   // default parameter values
   localparam int LBC_SAMPLE_WIDTH   = 16;
   localparam int LBC_COEF_FRAC_BITS = 22;

   // fixed arithmetic widths
   localparam int COEF_WIDTH     = 24;
   localparam int GAIN_WIDTH     = 32;
   localparam int GAIN_FRAC_BITS = 32;
   localparam int STATE_WIDTH    = 48;
   localparam int STATE_FRAC     = 24;
   localparam int SPLIT_BITS     = 24;
   // multiplicand: up to w + 2*v1 + v2, two bits over the state width
   localparam int MOP_W          = STATE_WIDTH + 2;
   // coefficient operand: gain needs a sign bit above its 32 bits
   localparam int A_W            = GAIN_WIDTH + 1;
   // one multiplicand chunk, signed
   localparam int CHUNK_W        = MOP_W - SPLIT_BITS;
   localparam int PP_W           = A_W + CHUNK_W;
   localparam int PROD_W         = A_W + MOP_W;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_STAGE1_A1   = 3'd0,
      REG_STAGE1_A2   = 3'd1,
      REG_STAGE2_A1   = 3'd2,
      REG_STAGE2_A2   = 3'd3,
      REG_STAGE1_GAIN = 3'd4
   } lbc_reg_idx_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] s1_a1;
      logic signed [COEF_WIDTH-1:0] s1_a2;
      logic signed [COEF_WIDTH-1:0] s2_a1;
      logic signed [COEF_WIDTH-1:0] s2_a2;
      logic [GAIN_WIDTH-1:0]        gain;
   } lbc_coef_type;

   // control word fields
   typedef enum logic [1:0] {
      MUL_NONE = 2'd0,
      MUL_HI   = 2'd1,
      MUL_LO   = 2'd2
   } lbc_mul_op_type;

   typedef enum logic [2:0] {
      ASEL_S1A1 = 3'd0,
      ASEL_S1A2 = 3'd1,
      ASEL_S2A1 = 3'd2,
      ASEL_S2A2 = 3'd3,
      ASEL_GAIN = 3'd4
   } lbc_asel_type;

   typedef enum logic [2:0] {
      BSEL_D0  = 3'd0,
      BSEL_D1  = 3'd1,
      BSEL_D2  = 3'd2,
      BSEL_D3  = 3'd3,
      BSEL_ACC = 3'd4
   } lbc_bsel_type;

   typedef enum logic [1:0] {
      PA_HOLD    = 2'd0,
      PA_LOAD_HI = 2'd1,
      PA_ADD_LO  = 2'd2
   } lbc_pa_op_type;

   typedef enum logic [2:0] {
      ACC_HOLD          = 3'd0,
      ACC_LOAD_X        = 3'd1,
      ACC_SUB_COEF      = 3'd2,
      ACC_LOAD_GAIN_SAT = 3'd3,
      ACC_SAT_ADD_T     = 3'd4
   } lbc_acc_op_type;

   typedef enum logic {
      SEC_ONE = 1'b0,
      SEC_TWO = 1'b1
   } lbc_sec_type;

   typedef enum logic [1:0] {
      SEQ_NEXT     = 2'd0,
      SEQ_WAIT_IN  = 2'd1,
      SEQ_WAIT_OUT = 2'd2,
      SEQ_JUMP     = 2'd3
   } lbc_cond_type;

   localparam int UC_PC_W = 5;

   // step addresses the program jumps to
   localparam logic [UC_PC_W-1:0] UC_ENTRY = 5'd0;
   localparam logic [UC_PC_W-1:0] UC_WORK  = 5'd1;

   typedef struct packed {
      lbc_mul_op_type       mul_op;
      lbc_asel_type         asel;
      lbc_bsel_type         bsel;
      lbc_pa_op_type        pa_op;
      lbc_acc_op_type       acc_op;
      logic                 tr_load;
      lbc_sec_type          tr_sec;
      logic                 dw_shift;
      lbc_sec_type          dw_sec;
      logic                 out_load;
      lbc_cond_type         cond;
      logic [UC_PC_W-1:0]   target;
   } lbc_ctrl_type;

   localparam lbc_ctrl_type UC_NOP = '{
      mul_op:   MUL_NONE,
      asel:     ASEL_S1A1,
      bsel:     BSEL_D0,
      pa_op:    PA_HOLD,
      acc_op:   ACC_HOLD,
      tr_load:  1'b0,
      tr_sec:   SEC_ONE,
      dw_shift: 1'b0,
      dw_sec:   SEC_ONE,
      out_load: 1'b0,
      cond:     SEQ_NEXT,
      target:   UC_ENTRY
   };

   // microprogram rom: one control word per step
   // each product takes a high-chunk pass followed by a low-chunk pass
   function automatic lbc_ctrl_type lbc_ucode(input logic [UC_PC_W-1:0] pc);
      lbc_ctrl_type c;
      c = UC_NOP;
      unique case (pc)
         // wait for a sample; start s1 a1*v1 and 2*v1+v2 meanwhile
         5'd0: begin
            c.acc_op  = ACC_LOAD_X;
            c.mul_op  = MUL_HI;
            c.asel    = ASEL_S1A1;
            c.bsel    = BSEL_D0;
            c.tr_load = 1'b1;
            c.tr_sec  = SEC_ONE;
            c.cond    = SEQ_WAIT_IN;
            c.target  = UC_WORK;
         end
         5'd1: begin
            c.mul_op = MUL_LO;
            c.asel   = ASEL_S1A1;
            c.bsel   = BSEL_D0;
            c.pa_op  = PA_LOAD_HI;
         end
         5'd2: begin
            c.pa_op  = PA_ADD_LO;
            c.mul_op = MUL_HI;
            c.asel   = ASEL_S1A2;
            c.bsel   = BSEL_D1;
         end
         5'd3: begin
            c.acc_op = ACC_SUB_COEF;
            c.mul_op = MUL_LO;
            c.asel   = ASEL_S1A2;
            c.bsel   = BSEL_D1;
            c.pa_op  = PA_LOAD_HI;
         end
         5'd4: begin
            c.pa_op = PA_ADD_LO;
         end
         5'd5: begin
            c.acc_op = ACC_SUB_COEF;
         end
         // w1 saturates, shifts into the s1 delays, acc becomes the numerator
         5'd6: begin
            c.acc_op   = ACC_SAT_ADD_T;
            c.dw_shift = 1'b1;
            c.dw_sec   = SEC_ONE;
            c.tr_load  = 1'b1;
            c.tr_sec   = SEC_TWO;
         end
         5'd7: begin
            c.mul_op = MUL_HI;
            c.asel   = ASEL_GAIN;
            c.bsel   = BSEL_ACC;
         end
         5'd8: begin
            c.mul_op = MUL_LO;
            c.asel   = ASEL_GAIN;
            c.bsel   = BSEL_ACC;
            c.pa_op  = PA_LOAD_HI;
         end
         5'd9: begin
            c.pa_op  = PA_ADD_LO;
            c.mul_op = MUL_HI;
            c.asel   = ASEL_S2A1;
            c.bsel   = BSEL_D2;
         end
         5'd10: begin
            c.acc_op = ACC_LOAD_GAIN_SAT;
            c.mul_op = MUL_LO;
            c.asel   = ASEL_S2A1;
            c.bsel   = BSEL_D2;
            c.pa_op  = PA_LOAD_HI;
         end
         5'd11: begin
            c.pa_op  = PA_ADD_LO;
            c.mul_op = MUL_HI;
            c.asel   = ASEL_S2A2;
            c.bsel   = BSEL_D3;
         end
         5'd12: begin
            c.acc_op = ACC_SUB_COEF;
            c.mul_op = MUL_LO;
            c.asel   = ASEL_S2A2;
            c.bsel   = BSEL_D3;
            c.pa_op  = PA_LOAD_HI;
         end
         5'd13: begin
            c.pa_op = PA_ADD_LO;
         end
         5'd14: begin
            c.acc_op = ACC_SUB_COEF;
         end
         5'd15: begin
            c.acc_op   = ACC_SAT_ADD_T;
            c.dw_shift = 1'b1;
            c.dw_sec   = SEC_TWO;
         end
         // hand the sample to the output register once it is free
         5'd16: begin
            c.out_load = 1'b1;
            c.cond     = SEQ_WAIT_OUT;
            c.target   = UC_ENTRY;
         end
         default: begin
            c.cond   = SEQ_JUMP;
            c.target = UC_ENTRY;
         end
      endcase
      return c;
   endfunction

endpackage

/* design/lowpass_biquad_cascade_filter.sv */
// Fourth-order low-pass filter: two Direct Form II biquads (taps 1,2,1) in
// cascade, feedback taps and section-one gain from configuration registers.
// The sequencer runs a 17-step microprogram (its first step waits for the
// input) that feeds ten partial products (five products, each in a high
// 26-bit and a low 24-bit chunk) through the one shared 33x26 multiplier,
// with section two waiting on section one's output. A new sample is taken
// only when the program is back at its first step, so a sample is finished
// before the next is taken; a finished sample waits in the output register
// and the program holds at its last step while that register is stalled.
// Depends on lbc_pkg, lbc_csr, lbc_useq and lbc_datapath.

module lowpass_biquad_cascade_filter
   import lbc_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = LBC_SAMPLE_WIDTH,
   parameter int COEF_FRAC_BITS = LBC_COEF_FRAC_BITS
)
(
   input  logic                           clock,
   input  logic                           reset,
   // input sample channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   // filtered sample channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [CSR_DATA_W-1:0]          csr_pwdata,
   output logic [CSR_DATA_W-1:0]          csr_prdata,
   output logic                           csr_pready
);

   lbc_coef_type coef;
   lbc_ctrl_type ctrl;
   logic         at_entry;
   logic         out_busy;

   // a sample transfer happens only at the program's first step
   assign req_stall = !at_entry;

   lbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   lbc_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_busy  (out_busy),
      .at_entry  (at_entry),
      .ctrl      (ctrl)
   );

   lbc_datapath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .coef           (coef),
      .req_sample_in  (req_sample_in),
      .out_busy       (out_busy),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out),
      .rsp_stall      (rsp_stall)
   );

endmodule

/* design/lbc_csr.sv */
// lbc_csr: apb-style configuration registers (feedback taps and gain)
// depends on lbc_pkg for register codes and the coefficient struct

module lbc_csr
   import lbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output lbc_coef_type          coef
);

   lbc_coef_type    coef_ff, coef_in;
   lbc_reg_idx_type idx;
   logic            wr_en;

   assign idx        = lbc_reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign coef       = coef_ff;

   // register write decode
   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         unique case (idx)
            REG_STAGE1_A1:   coef_in.s1_a1 = csr_pwdata[COEF_WIDTH-1:0];
            REG_STAGE1_A2:   coef_in.s1_a2 = csr_pwdata[COEF_WIDTH-1:0];
            REG_STAGE2_A1:   coef_in.s2_a1 = csr_pwdata[COEF_WIDTH-1:0];
            REG_STAGE2_A2:   coef_in.s2_a2 = csr_pwdata[COEF_WIDTH-1:0];
            REG_STAGE1_GAIN: coef_in.gain  = csr_pwdata[GAIN_WIDTH-1:0];
            default:         coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_STAGE1_A1:   csr_prdata = CSR_DATA_W'(unsigned'(coef_ff.s1_a1));
         REG_STAGE1_A2:   csr_prdata = CSR_DATA_W'(unsigned'(coef_ff.s1_a2));
         REG_STAGE2_A1:   csr_prdata = CSR_DATA_W'(unsigned'(coef_ff.s2_a1));
         REG_STAGE2_A2:   csr_prdata = CSR_DATA_W'(unsigned'(coef_ff.s2_a2));
         REG_STAGE1_GAIN: csr_prdata = CSR_DATA_W'(coef_ff.gain);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

/* design/lbc_useq.sv */
// lbc_useq: step counter and microprogram rom with conditional jumps
// depends on lbc_pkg for the control word and the rom contents

module lbc_useq
   import lbc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         out_busy,
   output logic         at_entry,
   output lbc_ctrl_type ctrl
);

   logic [UC_PC_W-1:0] pc_ff, pc_in;

   assign ctrl     = lbc_ucode(pc_ff);
   assign at_entry = (pc_ff == UC_ENTRY);

   // next step
   always_comb begin
      unique case (ctrl.cond)
         SEQ_NEXT:     pc_in = pc_ff + UC_PC_W'(1);
         SEQ_WAIT_IN:  pc_in = req_valid ? ctrl.target : pc_ff;
         SEQ_WAIT_OUT: pc_in = out_busy ? pc_ff : ctrl.target;
         SEQ_JUMP:     pc_in = ctrl.target;
         default:      pc_in = UC_ENTRY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= UC_ENTRY;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

/* design/lbc_datapath.sv */
// lbc_datapath: shared multiplier, product and sample accumulators, delay
// words and output register, all steered by the microprogram control word
// depends on lbc_pkg for widths, control word and coefficient struct

module lbc_datapath
   import lbc_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = LBC_SAMPLE_WIDTH,
   parameter int COEF_FRAC_BITS = LBC_COEF_FRAC_BITS
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  lbc_ctrl_type                   ctrl,
   input  lbc_coef_type                   coef,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                           out_busy,
   output logic                           rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input  logic                           rsp_stall
);

   localparam int ALIGN = STATE_FRAC - (SAMPLE_WIDTH - 1);
   // holds x minus two coefficient products with headroom
   localparam int ACC_W = PROD_W - COEF_FRAC_BITS + 2;

   logic signed [STATE_WIDTH-1:0]  delay_ff [4];
   logic signed [STATE_WIDTH-1:0]  delay_in [4];
   logic signed [A_W-1:0]          mul_a;
   logic signed [MOP_W-1:0]        mul_src;
   logic signed [CHUNK_W-1:0]      mul_b;
   logic signed [PP_W-1:0]         preg_ff;
   logic signed [PROD_W-1:0]       pacc_ff, pacc_in;
   logic signed [PROD_W-1:0]       psh_coef_full, psh_gain_full;
   logic signed [ACC_W-1:0]        psh_coef, psh_gain;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [ACC_W-1:0]        x_ext;
   logic signed [STATE_WIDTH-1:0]  acc_sat, gain_sat;
   logic signed [MOP_W-1:0]        treg_ff, treg_in;
   logic signed [STATE_WIDTH-1:0]  tap_v1, tap_v2;
   logic signed [ACC_W-1:0]        out_full;
   logic [ACC_W-SAMPLE_WIDTH:0]    out_top;
   logic signed [SAMPLE_WIDTH-1:0] out_sat;
   logic                           out_ld;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out_ff;

   // clamp to the signed state range
   function automatic logic signed [STATE_WIDTH-1:0] sat_state(
      input logic signed [ACC_W-1:0] v);
      logic [ACC_W-STATE_WIDTH:0] top;
      top = v[ACC_W-1:STATE_WIDTH-1];
      if ((&top) || !(|top))
         return v[STATE_WIDTH-1:0];
      else if (v[ACC_W-1])
         return {1'b1, {(STATE_WIDTH-1){1'b0}}};
      else
         return {1'b0, {(STATE_WIDTH-1){1'b1}}};
   endfunction

   // multiplier operand a: coefficient or gain
   always_comb begin
      unique case (ctrl.asel)
         ASEL_S1A1: mul_a = A_W'(coef.s1_a1);
         ASEL_S1A2: mul_a = A_W'(coef.s1_a2);
         ASEL_S2A1: mul_a = A_W'(coef.s2_a1);
         ASEL_S2A2: mul_a = A_W'(coef.s2_a2);
         ASEL_GAIN: mul_a = $signed({1'b0, coef.gain});
         default:   mul_a = '0;
      endcase
   end

   // multiplier operand b: delay word or numerator, one chunk at a time
   always_comb begin
      unique case (ctrl.bsel)
         BSEL_D0:  mul_src = MOP_W'(delay_ff[0]);
         BSEL_D1:  mul_src = MOP_W'(delay_ff[1]);
         BSEL_D2:  mul_src = MOP_W'(delay_ff[2]);
         BSEL_D3:  mul_src = MOP_W'(delay_ff[3]);
         BSEL_ACC: mul_src = acc_ff[MOP_W-1:0];
         default:  mul_src = '0;
      endcase
      if (ctrl.mul_op == MUL_HI)
         mul_b = mul_src[MOP_W-1:SPLIT_BITS];
      else
         mul_b = {{(CHUNK_W-SPLIT_BITS){1'b0}}, mul_src[SPLIT_BITS-1:0]};
   end

   // product accumulator: high chunk first, then low chunk added
   always_comb begin
      unique case (ctrl.pa_op)
         PA_HOLD:    pacc_in = pacc_ff;
         PA_LOAD_HI: pacc_in = PROD_W'(preg_ff) <<< SPLIT_BITS;
         PA_ADD_LO:  pacc_in = pacc_ff + PROD_W'(preg_ff);
         default:    pacc_in = pacc_ff;
      endcase
   end

   // floored products at their fraction points
   assign psh_coef_full = pacc_ff >>> COEF_FRAC_BITS;
   assign psh_gain_full = pacc_ff >>> GAIN_FRAC_BITS;
   assign psh_coef      = psh_coef_full[ACC_W-1:0];
   assign psh_gain      = psh_gain_full[ACC_W-1:0];
   assign acc_sat       = sat_state(acc_ff);
   assign gain_sat      = sat_state(psh_gain);
   assign x_ext         = ACC_W'(req_sample_in) <<< ALIGN;

   // sample accumulator
   always_comb begin
      unique case (ctrl.acc_op)
         ACC_HOLD:          acc_in = acc_ff;
         ACC_LOAD_X:        acc_in = x_ext;
         ACC_SUB_COEF:      acc_in = acc_ff - psh_coef;
         ACC_LOAD_GAIN_SAT: acc_in = ACC_W'(gain_sat);
         ACC_SAT_ADD_T:     acc_in = ACC_W'(acc_sat) + ACC_W'(treg_ff);
         default:           acc_in = acc_ff;
      endcase
   end

   // numerator tail 2*v1 + v2 of the selected section
   always_comb begin
      unique case (ctrl.tr_sec)
         SEC_ONE: begin
            tap_v1 = delay_ff[0];
            tap_v2 = delay_ff[1];
         end
         SEC_TWO: begin
            tap_v1 = delay_ff[2];
            tap_v2 = delay_ff[3];
         end
         default: begin
            tap_v1 = delay_ff[0];
            tap_v2 = delay_ff[1];
         end
      endcase
      treg_in = treg_ff;
      if (ctrl.tr_load)
         treg_in = (MOP_W'(tap_v1) <<< 1) + MOP_W'(tap_v2);
   end

   // delay shift: v2 takes v1, v1 takes the saturated w
   always_comb begin
      delay_in = delay_ff;
      if (ctrl.dw_shift) begin
         unique case (ctrl.dw_sec)
            SEC_ONE: begin
               delay_in[1] = delay_ff[0];
               delay_in[0] = acc_sat;
            end
            SEC_TWO: begin
               delay_in[3] = delay_ff[2];
               delay_in[2] = acc_sat;
            end
            default: delay_in = delay_ff;
         endcase
      end
   end

   // output conversion: floor to sample fraction, clamp to sample range
   always_comb begin
      out_full = acc_ff >>> ALIGN;
      out_top  = out_full[ACC_W-1:SAMPLE_WIDTH-1];
      if ((&out_top) || !(|out_top))
         out_sat = out_full[SAMPLE_WIDTH-1:0];
      else if (out_full[ACC_W-1])
         out_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      else
         out_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   end

   assign out_busy       = rsp_valid_ff && rsp_stall;
   assign out_ld         = ctrl.out_load && !out_busy;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

   // datapath payload registers
   always_ff @(posedge clock) begin
      if (ctrl.mul_op != MUL_NONE) begin
         preg_ff <= PP_W'(mul_a) * PP_W'(mul_b);
      end
      pacc_ff <= pacc_in;
      acc_ff  <= acc_in;
      treg_ff <= treg_in;
      if (out_ld) begin
         rsp_sample_out_ff <= out_sat;
      end
   end

   // filter state and output transfer flag
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         delay_ff <= delay_in;
         if (out_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
